/* sv/cwes_pkg.sv */
// shared types and constants for the calorimeter window energy sum block
`default_nettype none

package cwes_pkg;

  // default sizing
  localparam int NUM_LAYERS_DEF = 28;
  localparam int SUM_WIDTH_DEF  = 32;

  // field widths
  localparam int ETA_W    = 16;
  localparam int PHI_W    = 15;
  localparam int ENERGY_W = 24;
  localparam int LAYER_W  = 5;
  localparam int HW_W     = 12;
  localparam int MASK_W   = 28;
  localparam int COUNT_W  = 16;
  localparam int OUT_W    = 32;
  localparam int EXT_W    = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 28;

  // window arithmetic width, wide enough for |eta difference|
  localparam int DW = 18;

  // pi and 2*pi in 2^-12 rad
  localparam logic signed [DW-1:0] PHI_PI_FX     = 18'sd12868;
  localparam logic signed [DW-1:0] PHI_TWO_PI_FX = 18'sd25736;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // register reset values
  localparam logic signed [ETA_W-1:0] SEED_ETA_RST   = '0;
  localparam logic signed [PHI_W-1:0] SEED_PHI_RST   = '0;
  localparam logic [HW_W-1:0]         HALF_WIDTH_RST = 12'd492;
  localparam logic [MASK_W-1:0]       FIRST_MASK_RST = 28'd364800;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEED_ETA   = 2'd0,
    CFG_SEED_PHI   = 2'd1,
    CFG_HALF_WIDTH = 2'd2,
    CFG_FIRST_MASK = 2'd3
  } cfg_idx_t;

endpackage

`default_nettype wire

/* sv/cwes_sat_add.sv */
// saturating signed accumulate of one energy into a sum
`default_nettype none

module cwes_sat_add #(
  parameter int SUM_WIDTH = cwes_pkg::SUM_WIDTH_DEF,
  parameter int E_W       = cwes_pkg::ENERGY_W
) (
  input  wire logic signed [SUM_WIDTH-1:0] acc,
  input  wire logic signed [E_W-1:0]       addend,
  output logic signed [SUM_WIDTH-1:0]      sum
);

  localparam int AW = ((SUM_WIDTH > E_W) ? SUM_WIDTH : E_W) + 1;

  logic signed [AW-1:0] wide;
  logic signed [AW-1:0] hi;
  logic signed [AW-1:0] lo;

  assign wide = AW'(acc) + AW'(addend);
  assign hi   = AW'({1'b0, {(SUM_WIDTH-1){1'b1}}});
  assign lo   = ~hi;

  always_comb begin
    if (wide > hi) begin
      sum = hi[SUM_WIDTH-1:0];
    end else if (wide < lo) begin
      sum = lo[SUM_WIDTH-1:0];
    end else begin
      sum = wide[SUM_WIDTH-1:0];
    end
  end

endmodule

`default_nettype wire

/* sv/calo_window_energy_sum.sv */
// top level: window test and per-layer energy accumulation of calorimeter cells
// a request is held in the input register, and its result in the result register
// throughput: one request per cycle while the result side does not stall, window test and accumulate in one short pass
// stalls on the result side back up through the input register
// reset clears the pipeline, all layer sums, the first layer sum and the count,
// and returns the configuration registers to their defaults
`default_nettype none

module calo_window_energy_sum #(
  parameter int NUM_LAYERS = cwes_pkg::NUM_LAYERS_DEF,
  parameter int SUM_WIDTH  = cwes_pkg::SUM_WIDTH_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // configuration
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [cwes_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [cwes_pkg::CFG_DATA_W-1:0]        cfg_data,
  // cell input
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic signed [cwes_pkg::ETA_W-1:0]      cell_eta,
  input  wire logic signed [cwes_pkg::PHI_W-1:0]      cell_phi,
  input  wire logic signed [cwes_pkg::ENERGY_W-1:0]   cell_energy,
  input  wire logic [cwes_pkg::LAYER_W-1:0]           layer_id,
  input  wire logic                                   first_cell,
  // result
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic                                        in_window,
  output logic signed [cwes_pkg::OUT_W-1:0]           layer_total,
  output logic signed [cwes_pkg::OUT_W-1:0]           first_layer_total,
  output logic [cwes_pkg::COUNT_W-1:0]                cells_seen
);

  localparam int LIDX_W = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
  localparam int DW     = cwes_pkg::DW;

  // configuration registers
  logic signed [cwes_pkg::ETA_W-1:0] seed_eta;
  logic signed [cwes_pkg::PHI_W-1:0] seed_phi;
  logic [cwes_pkg::HW_W-1:0]         half_width;
  logic [cwes_pkg::MASK_W-1:0]       first_mask;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_eta   <= cwes_pkg::SEED_ETA_RST;
      seed_phi   <= cwes_pkg::SEED_PHI_RST;
      half_width <= cwes_pkg::HALF_WIDTH_RST;
      first_mask <= cwes_pkg::FIRST_MASK_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cwes_pkg::cfg_idx_t'(cfg_index))
        cwes_pkg::CFG_SEED_ETA:   seed_eta   <= cfg_data[cwes_pkg::ETA_W-1:0];
        cwes_pkg::CFG_SEED_PHI:   seed_phi   <= cfg_data[cwes_pkg::PHI_W-1:0];
        cwes_pkg::CFG_HALF_WIDTH: half_width <= cfg_data[cwes_pkg::HW_W-1:0];
        cwes_pkg::CFG_FIRST_MASK: first_mask <= cfg_data[cwes_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic s1_valid;
  logic out_free;
  logic s1_free;
  logic s1_fire;

  assign out_free = !out_valid || out_ready;
  assign s1_free  = !s1_valid || out_free;
  assign in_ready = s1_free;
  assign s1_fire  = s1_valid && out_free;

  // stage 1: input register
  logic signed [cwes_pkg::ETA_W-1:0]    s1_eta;
  logic signed [cwes_pkg::PHI_W-1:0]    s1_phi;
  logic signed [cwes_pkg::ENERGY_W-1:0] s1_energy;
  logic [cwes_pkg::LAYER_W-1:0]         s1_layer;
  logic                                 s1_first;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_eta    <= cell_eta;
      s1_phi    <= cell_phi;
      s1_energy <= cell_energy;
      s1_layer  <= layer_id;
      s1_first  <= first_cell;
    end
  end

  // window test
  logic signed [DW-1:0] deta;
  logic signed [DW-1:0] deta_abs;
  logic signed [DW-1:0] dphi;
  logic signed [DW-1:0] dphi_abs;
  logic signed [DW-1:0] dphi_wrap;
  logic signed [DW-1:0] hw_s;
  logic                 s1_inside;

  assign deta      = DW'(s1_eta) - DW'(seed_eta);
  assign deta_abs  = (deta < 0) ? -deta : deta;
  assign dphi      = DW'(s1_phi) - DW'(seed_phi);
  assign dphi_abs  = (dphi < 0) ? -dphi : dphi;
  assign dphi_wrap = (dphi_abs > cwes_pkg::PHI_PI_FX) ?
                     (cwes_pkg::PHI_TWO_PI_FX - dphi_abs) : dphi_abs;
  assign hw_s      = DW'({1'b0, half_width});
  assign s1_inside = (deta_abs <= hw_s) && (dphi_wrap <= hw_s);

  // accumulation state
  logic signed [SUM_WIDTH-1:0]   layer_sums [NUM_LAYERS];
  logic signed [SUM_WIDTH-1:0]   first_sum;
  logic [cwes_pkg::COUNT_W-1:0]  cell_count;

  logic [LIDX_W-1:0]             lidx;
  logic                          layer_ok;
  logic                          mask_hit;
  logic [31:0]                   mask_ext;
  logic signed [SUM_WIDTH-1:0]   layer_base;
  logic signed [SUM_WIDTH-1:0]   first_base;
  logic signed [SUM_WIDTH-1:0]   layer_add;
  logic signed [SUM_WIDTH-1:0]   first_add;
  logic signed [SUM_WIDTH-1:0]   layer_next;
  logic signed [SUM_WIDTH-1:0]   first_sum_next;
  logic [cwes_pkg::COUNT_W-1:0]  count_base;
  logic [cwes_pkg::COUNT_W-1:0]  cell_count_next;
  logic signed [cwes_pkg::EXT_W-1:0] layer_ext;
  logic signed [cwes_pkg::EXT_W-1:0] first_ext;

  assign lidx       = LIDX_W'(s1_layer);
  assign layer_ok   = 32'(s1_layer) < 32'(NUM_LAYERS);
  assign mask_ext   = 32'(first_mask);
  assign mask_hit   = mask_ext[s1_layer];
  assign layer_base = (s1_first || !layer_ok) ? '0 : layer_sums[lidx];
  assign first_base = s1_first ? '0 : first_sum;
  assign count_base = s1_first ? '0 : cell_count;

  cwes_sat_add #(
    .SUM_WIDTH (SUM_WIDTH),
    .E_W       (cwes_pkg::ENERGY_W)
  ) u_layer_add (
    .acc    (layer_base),
    .addend (s1_energy),
    .sum    (layer_add)
  );

  cwes_sat_add #(
    .SUM_WIDTH (SUM_WIDTH),
    .E_W       (cwes_pkg::ENERGY_W)
  ) u_first_add (
    .acc    (first_base),
    .addend (s1_energy),
    .sum    (first_add)
  );

  assign layer_next      = (s1_inside && layer_ok) ? layer_add : layer_base;
  assign first_sum_next  = (s1_inside && layer_ok && mask_hit) ? first_add : first_base;
  assign cell_count_next = (count_base == cwes_pkg::COUNT_MAX) ?
                           count_base : count_base + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LAYERS; i++) begin
        layer_sums[i] <= '0;
      end
      first_sum  <= '0;
      cell_count <= '0;
    end else if (s1_fire) begin
      for (int i = 0; i < NUM_LAYERS; i++) begin
        if (layer_ok && (LIDX_W'(i) == lidx)) begin
          layer_sums[i] <= layer_next;
        end else if (s1_first) begin
          layer_sums[i] <= '0;
        end
      end
      first_sum  <= first_sum_next;
      cell_count <= cell_count_next;
    end
  end

  // result register
  assign layer_ext = cwes_pkg::EXT_W'(layer_next);
  assign first_ext = cwes_pkg::EXT_W'(first_sum_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      in_window         <= s1_inside;
      layer_total       <= layer_ok ? layer_ext[cwes_pkg::OUT_W-1:0] : '0;
      first_layer_total <= first_ext[cwes_pkg::OUT_W-1:0];
      cells_seen        <= cell_count_next;
    end
  end

endmodule

`default_nettype wire

/* sv/cwes_checker.sv */
// port-level checks for the window energy sum block, bound to the top level
`default_nettype none

module cwes_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic                              in_window,
  input wire logic [cwes_pkg::OUT_W-1:0]        layer_total,
  input wire logic [cwes_pkg::OUT_W-1:0]        first_layer_total,
  input wire logic [cwes_pkg::COUNT_W-1:0]      cells_seen
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(in_window) &&
    $stable(layer_total) && $stable(first_layer_total) && $stable(cells_seen))
    else $error("result changed while stalled");

  // every result counts at least its own cell
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cells_seen != '0)
    else $error("result with zero cell count");

  // input back-pressure only comes from a stalled, full result side
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output stall");

  // a waiting request stays offered
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid)
    else $error("request dropped before acceptance");

  // nothing is shown right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind calo_window_energy_sum cwes_checker u_cwes_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .in_window         (in_window),
  .layer_total       (layer_total),
  .first_layer_total (first_layer_total),
  .cells_seen        (cells_seen)
);

`default_nettype wire
